@@ rtl/macd_pkg.sv @@
// macd_pkg: shared widths, codes, reset weights and saturation helper
// for the macd indicator block; no dependencies
`default_nettype none

package macd_pkg;

    localparam int PRICE_W = 32;
    localparam int OUT_W   = 32;
    localparam int AVG_W   = 33;
    localparam int DIFF_W  = 34;
    localparam int MAG_W   = 33;
    localparam int IDX_W   = 2;

    localparam logic [31:0] FAST_WEIGHT_RST   = 32'd10082;
    localparam logic [31:0] SLOW_WEIGHT_RST   = 32'd4855;
    localparam logic [31:0] SIGNAL_WEIGHT_RST = 32'd13107;

    typedef enum logic [IDX_W-1:0] {
        CFG_FAST   = 2'd0,
        CFG_SLOW   = 2'd1,
        CFG_SIGNAL = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SEL_FAST   = 2'd0,
        SEL_SLOW   = 2'd1,
        SEL_SIGNAL = 2'd2
    } t_avg_sel;

    function automatic logic [OUT_W-1:0] sat32(input logic signed [DIFF_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (v[DIFF_W-1:OUT_W-1] == '0 || v[DIFF_W-1:OUT_W-1] == '1) begin
            r = v[OUT_W-1:0];
        end else if (v[DIFF_W-1]) begin
            r = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(OUT_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/macd_if.sv @@
// macd_if: valid/ready channel interfaces for bars, results and weight writes
// no dependencies
`default_nettype none

interface macd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] close_price;
    logic        series_start;

    modport source (output valid, output close_price, output series_start, input ready);
    modport sink   (input valid, input close_price, input series_start, output ready);
endinterface

interface macd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] macd_line;
    logic signed [31:0] signal_line;
    logic signed [31:0] histogram;

    modport source (output valid, output macd_line, output signal_line, output histogram,
                    input ready);
    modport sink   (input valid, input macd_line, input signal_line, input histogram,
                    output ready);
endinterface

interface macd_cfg_if #(
    parameter int WEIGHT_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             index;
    logic [WEIGHT_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/macd_cfg_regs.sv @@
// macd_cfg_regs: the three average weights, written over the config channel
// depends on macd_pkg and macd_cfg_if
`default_nettype none

module macd_cfg_regs import macd_pkg::*; #(
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    macd_cfg_if.sink                    i_cfg,
    input  wire t_avg_sel               i_sel,
    output logic [WEIGHT_BITS-1:0]      o_weight
);

    logic [WEIGHT_BITS-1:0] r_fast_w;
    logic [WEIGHT_BITS-1:0] r_slow_w;
    logic [WEIGHT_BITS-1:0] r_sig_w;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_w <= FAST_WEIGHT_RST[WEIGHT_BITS-1:0];
            r_slow_w <= SLOW_WEIGHT_RST[WEIGHT_BITS-1:0];
            r_sig_w  <= SIGNAL_WEIGHT_RST[WEIGHT_BITS-1:0];
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FAST:   r_fast_w <= i_cfg.data;
                CFG_SLOW:   r_slow_w <= i_cfg.data;
                CFG_SIGNAL: r_sig_w  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_sel)
            SEL_FAST:   o_weight = r_fast_w;
            SEL_SLOW:   o_weight = r_slow_w;
            SEL_SIGNAL: o_weight = r_sig_w;
            default:    o_weight = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/macd_ser_mul.sv @@
// macd_ser_mul: bit-serial multiplier, one weight bit per cycle,
// gives floor(mag * weight / 2^WEIGHT_BITS); depends on macd_pkg
`default_nettype none

module macd_ser_mul import macd_pkg::*; #(
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [MAG_W-1:0]       i_mag,
    input  wire logic [WEIGHT_BITS-1:0] i_weight,
    output logic                        o_done,
    output logic [MAG_W-1:0]            o_prod
);

    localparam int CNT_W = $clog2(WEIGHT_BITS + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [MAG_W-1:0]       r_mag;
    logic [MAG_W-1:0]       r_acc;
    logic [WEIGHT_BITS-1:0] r_wsr;
    logic [MAG_W:0]         n_sum;

    // partial product added, then shifted out one bit
    assign n_sum = {1'b0, r_acc} + (r_wsr[0] ? {1'b0, r_mag} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WEIGHT_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_mag;
            r_acc <= '0;
            r_wsr <= i_weight;
        end else if (r_busy) begin
            r_acc <= n_sum[MAG_W:1];
            r_wsr <= r_wsr >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

@@ rtl/macd_indicator.sv @@
// macd_indicator: top level, fast/slow/signal exponential averages per bar
// depends on macd_pkg, macd_if, macd_cfg_regs, macd_ser_mul
//
//  channel  | dir | handshake     | payload
//  i_bar    | in  | valid/ready   | close_price[31:0], series_start
//  o_result | out | valid/ready   | macd_line, signal_line, histogram (signed 32)
//  i_cfg    | in  | valid/ready   | index[1:0], data[WEIGHT_BITS-1:0]
//
// one bar at a time; the three average updates share the bit-serial multiplier,
// each update passing through setup, multiplier start, multiply and apply; a later
// bar runs all three updates, the second bar two, and a series start none
// synchronous active-low reset clears control state and restores default weights
// a stalled result sits in the output register; the next bar is taken meanwhile
// and waits in the final step only if the result is still not taken
`default_nettype none

module macd_indicator import macd_pkg::*; #(
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    macd_in_if.sink   i_bar,
    macd_out_if.source o_result,
    macd_cfg_if.sink  i_cfg
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SETUP  = 7'b0000010,
        ST_MSTART = 7'b0000100,
        ST_MUL    = 7'b0001000,
        ST_APPLY  = 7'b0010000,
        ST_DIFF   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } t_state;

    t_state                   r_state;
    t_avg_sel                 r_sel;
    logic [1:0]               r_bars;
    logic                     r_zero;
    logic [PRICE_W-1:0]       r_price;
    logic signed [AVG_W-1:0]  r_fast;
    logic signed [AVG_W-1:0]  r_slow;
    logic signed [AVG_W-1:0]  r_sig;
    logic signed [AVG_W-1:0]  r_diff;
    logic signed [DIFF_W-1:0] r_d;
    logic                     r_out_valid;
    logic [OUT_W-1:0]         r_macd;
    logic [OUT_W-1:0]         r_signal;
    logic [OUT_W-1:0]         r_hist;

    logic [WEIGHT_BITS-1:0]   w_weight;
    logic                     w_mul_start;
    logic                     w_mul_done;
    logic [MAG_W-1:0]         w_mag;
    logic [MAG_W-1:0]         w_prod;
    logic signed [AVG_W-1:0]  w_x;
    logic signed [AVG_W-1:0]  w_avg;
    logic signed [DIFF_W-1:0] n_d;
    logic signed [DIFF_W-1:0] n_avg;
    logic signed [DIFF_W-1:0] n_diff;
    logic signed [DIFF_W-1:0] n_hist;
    logic signed [DIFF_W-1:0] w_neg_d;
    logic                     w_bar_acc;
    logic                     w_out_free;

    macd_cfg_regs #(.WEIGHT_BITS(WEIGHT_BITS)) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_sel    (r_sel),
        .o_weight (w_weight)
    );

    macd_ser_mul #(.WEIGHT_BITS(WEIGHT_BITS)) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mag    (w_mag),
        .i_weight (w_weight),
        .o_done   (w_mul_done),
        .o_prod   (w_prod)
    );

    assign i_bar.ready = (r_state == ST_IDLE);
    assign w_bar_acc   = i_bar.valid && (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || o_result.ready;

    always_comb begin
        case (r_sel)
            SEL_FAST:   w_avg = r_fast;
            SEL_SLOW:   w_avg = r_slow;
            SEL_SIGNAL: w_avg = r_sig;
            default:    w_avg = '0;
        endcase
    end

    assign w_x         = (r_sel == SEL_SIGNAL) ? r_diff : $signed({1'b0, r_price});
    assign n_d         = DIFF_W'(w_x) - DIFF_W'(w_avg);
    assign w_neg_d     = -r_d;
    assign w_mag       = r_d[DIFF_W-1] ? w_neg_d[MAG_W-1:0] : r_d[MAG_W-1:0];
    assign w_mul_start = (r_state == ST_MSTART);
    // move toward x, truncated toward zero
    assign n_avg       = r_d[DIFF_W-1] ? DIFF_W'(w_avg) - $signed({1'b0, w_prod})
                                       : DIFF_W'(w_avg) + $signed({1'b0, w_prod});
    assign n_diff      = DIFF_W'(r_fast) - DIFF_W'(r_slow);
    assign n_hist      = DIFF_W'(r_diff) - DIFF_W'(r_sig);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sel       <= SEL_FAST;
            r_bars      <= '0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_FINISH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_bar_acc) begin
                        r_sel <= SEL_FAST;
                        if (i_bar.series_start || r_bars == 2'd0) begin
                            r_bars  <= 2'd1;
                            r_zero  <= 1'b1;
                            r_state <= ST_FINISH;
                        end else begin
                            r_zero  <= 1'b0;
                            r_state <= ST_SETUP;
                        end
                    end
                end
                ST_SETUP:  r_state <= ST_MSTART;
                ST_MSTART: r_state <= ST_MUL;
                ST_MUL: begin
                    if (w_mul_done) begin
                        r_state <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    case (r_sel)
                        SEL_FAST: begin
                            r_sel   <= SEL_SLOW;
                            r_state <= ST_SETUP;
                        end
                        SEL_SLOW:   r_state <= ST_DIFF;
                        default:    r_state <= ST_FINISH;
                    endcase
                end
                ST_DIFF: begin
                    if (r_bars == 2'd1) begin
                        r_bars  <= 2'd2;
                        r_state <= ST_FINISH;
                    end else begin
                        r_sel   <= SEL_SIGNAL;
                        r_state <= ST_SETUP;
                    end
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast <= '0;
            r_slow <= '0;
            r_sig  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_bar_acc) begin
                        r_price <= i_bar.close_price;
                        if (i_bar.series_start || r_bars == 2'd0) begin
                            r_fast <= $signed({1'b0, i_bar.close_price});
                            r_slow <= $signed({1'b0, i_bar.close_price});
                            r_sig  <= '0;
                        end
                    end
                end
                ST_SETUP: r_d <= n_d;
                ST_APPLY: begin
                    case (r_sel)
                        SEL_FAST:   r_fast <= n_avg[AVG_W-1:0];
                        SEL_SLOW:   r_slow <= n_avg[AVG_W-1:0];
                        SEL_SIGNAL: r_sig  <= n_avg[AVG_W-1:0];
                        default: ;
                    endcase
                end
                ST_DIFF: begin
                    r_diff <= n_diff[AVG_W-1:0];
                    if (r_bars == 2'd1) begin
                        r_sig <= n_diff[AVG_W-1:0];
                    end
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_macd   <= r_zero ? '0 : sat32(DIFF_W'(r_diff));
                        r_signal <= r_zero ? '0 : sat32(DIFF_W'(r_sig));
                        r_hist   <= r_zero ? '0 : sat32(n_hist);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.macd_line   = r_macd;
    assign o_result.signal_line = r_signal;
    assign o_result.histogram   = r_hist;

endmodule

`default_nettype wire

@@ tb/sv/macd_indicator_checker.sv @@
// macd_indicator_checker: watches the bar, result and weight channels of the macd block,
// predicts each bar's difference, signal and histogram lines and compares them
// depends on macd_pkg
module macd_indicator_checker import macd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_bar_valid,
    input  logic        i_bar_ready,
    input  logic [31:0] i_bar_price,
    input  logic        i_bar_start,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [31:0] i_res_macd,
    input  logic [31:0] i_res_signal,
    input  logic [31:0] i_res_hist,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     WEIGHT_SHIFT = 16;
    localparam longint LINE_MAX     = 64'sd2147483647;
    localparam longint LINE_MIN     = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] macd_line;
        logic [31:0] signal_line;
        logic [31:0] histogram;
    } t_bar_lines;

    logic [15:0] fast_w;
    logic [15:0] slow_w;
    logic [15:0] signal_w;
    longint      fast_avg;
    longint      slow_avg;
    longint      signal_avg;
    logic [1:0]  bars_in_series;
    t_bar_lines  lines_due[$];
    int          mismatches = 0;

    function automatic longint ema_step(longint avg, longint target, logic [15:0] w);
        longint d;
        longint mag;
        longint wl;
        longint moved;
        d = target - avg;
        mag = (d < 0) ? -d : d;
        wl = longint'({48'd0, w});
        moved = (mag * wl) >>> WEIGHT_SHIFT;
        return (d < 0) ? avg - moved : avg + moved;
    endfunction

    function automatic logic [31:0] clip32(longint v);
        if (v > LINE_MAX) return 32'h7FFF_FFFF;
        if (v < LINE_MIN) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic t_bar_lines next_bar(logic [31:0] price, logic start);
        t_bar_lines r;
        longint     p;
        longint     diff;
        r = '0;
        p = longint'({32'd0, price});
        if (start || bars_in_series == 2'd0) begin
            fast_avg = p;
            slow_avg = p;
            signal_avg = 0;
            bars_in_series = 2'd1;
            return r;
        end
        fast_avg = ema_step(fast_avg, p, fast_w);
        slow_avg = ema_step(slow_avg, p, slow_w);
        diff = fast_avg - slow_avg;
        if (bars_in_series == 2'd1) begin
            signal_avg = diff;
            bars_in_series = 2'd2;
        end else begin
            signal_avg = ema_step(signal_avg, diff, signal_w);
        end
        r.macd_line = clip32(diff);
        r.signal_line = clip32(signal_avg);
        r.histogram = clip32(diff - signal_avg);
        return r;
    endfunction

    task automatic report(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_line(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report($sformatf("%s got %h expected %h", field, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_bar_lines want;
        if (!i_rst_n) begin
            fast_w = FAST_WEIGHT_RST[15:0];
            slow_w = SLOW_WEIGHT_RST[15:0];
            signal_w = SIGNAL_WEIGHT_RST[15:0];
            fast_avg = 0;
            slow_avg = 0;
            signal_avg = 0;
            bars_in_series = 2'd0;
            lines_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FAST: fast_w = i_cfg_data;
                    CFG_SLOW: slow_w = i_cfg_data;
                    CFG_SIGNAL: signal_w = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_bar_valid && i_bar_ready) begin
                lines_due.insert(lines_due.size(), next_bar(i_bar_price, i_bar_start));
            end
            if (i_res_valid && i_res_ready) begin
                if (lines_due.size() == 0) begin
                    report("result transaction with no bar outstanding");
                end else begin
                    want = lines_due.pop_front();
                    compare_line("macd_line", i_res_macd, want.macd_line);
                    compare_line("signal_line", i_res_signal, want.signal_line);
                    compare_line("histogram", i_res_hist, want.histogram);
                end
            end
        end
        o_pending <= lines_due.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ tb/sv/macd_indicator_tb.sv @@
// macd_indicator_tb: drives bars and weight writes into macd_indicator under varied idling and
// result stalls, checker alongside; depends on macd_pkg, macd_if, macd_indicator_checker
module macd_indicator_tb import macd_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int         PHASE_BARS = 170;
    localparam int         DRAIN_CYCLES = 120;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   fail_count;
    int   pending;

    macd_in_if                     bar_if ();
    macd_out_if                    res_if ();
    macd_cfg_if #(.WEIGHT_BITS(16)) cfg_if ();

    macd_indicator #(.WEIGHT_BITS(16)) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bar    (bar_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    macd_indicator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bar_valid  (bar_if.valid),
        .i_bar_ready  (bar_if.ready),
        .i_bar_price  (bar_if.close_price),
        .i_bar_start  (bar_if.series_start),
        .i_res_valid  (res_if.valid),
        .i_res_ready  (res_if.ready),
        .i_res_macd   (res_if.macd_line),
        .i_res_signal (res_if.signal_line),
        .i_res_hist   (res_if.histogram),
        .i_cfg_valid  (cfg_if.valid),
        .i_cfg_ready  (cfg_if.ready),
        .i_cfg_index  (cfg_if.index),
        .i_cfg_data   (cfg_if.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_bar(logic [31:0] price, logic start);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap != 0) begin
            bar_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        bar_if.valid <= 1'b1;
        bar_if.close_price <= price;
        bar_if.series_start <= start;
        @(posedge i_clk);
        while (!bar_if.ready) @(posedge i_clk);
    endtask

    task automatic wait_quiet();
        bar_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic put_weight(logic [1:0] idx, logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
    endtask

    task automatic set_weights(logic [15:0] fast, logic [15:0] slow, logic [15:0] sig);
        wait_quiet();
        put_weight(CFG_UNUSED, 16'($urandom));
        put_weight(CFG_FAST, fast);
        put_weight(CFG_SLOW, slow);
        put_weight(CFG_SIGNAL, sig);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_random_bars(int n_bars);
        int          sent;
        int          pause_at;
        int          len;
        int          k;
        int unsigned span;
        int unsigned pick;
        logic [31:0] level;
        logic [31:0] price;
        logic        start;
        sent = 0;
        pause_at = $urandom_range(n_bars / 4, 3 * n_bars / 4);
        while (sent < n_bars) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
            level = ($urandom_range(2) == 0) ? $urandom
                                             : {16'($urandom_range(4000)), 16'($urandom)};
            span = 1 << $urandom_range(4, 22);
            for (k = 0; k < len && sent < n_bars; k++) begin
                pick = $urandom_range(99);
                if (pick < 75) begin
                    level = level + $urandom_range(2 * span) - span;
                    price = level;
                end else if (pick < 88) begin
                    price = $urandom;
                end else if (pick < 94) begin
                    price = '0;
                end else begin
                    price = '1;
                end
                if (k == 0) begin
                    start = ($urandom_range(99) >= 8);
                end else begin
                    start = ($urandom_range(99) < 3);
                end
                send_bar(price, start);
                sent++;
                if (sent == pause_at) wait_quiet();
            end
        end
    endtask

    initial begin
        bar_if.valid <= 1'b0;
        bar_if.close_price <= '0;
        bar_if.series_start <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data <= '0;
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first bar after reset opens a series without the start flag
        send_bar(32'h1234_5678, 1'b0);
        send_bar(32'h0001_0000, 1'b0);
        send_bar(32'hFFFF_FFFF, 1'b0);
        send_bar(32'h0000_0000, 1'b0);
        send_bar(32'h8000_0000, 1'b1);
        send_bar(32'h7FFF_FFFF, 1'b0);

        // fast tracks nearly fully, slow frozen: wide differences saturate both ways
        set_weights(16'hFFFF, 16'h0000, 16'hFFFF);
        send_bar(32'h0000_0000, 1'b1);
        send_bar(32'hFFFF_FFFF, 1'b0);
        send_bar(32'hFFFF_FFFF, 1'b0);
        send_bar(32'h0000_0000, 1'b0);
        send_bar(32'h0000_0000, 1'b0);
        send_bar(32'hFFFF_FFFF, 1'b1);
        send_bar(32'h0000_0000, 1'b0);
        send_bar(32'hFFFF_FFFF, 1'b0);

        // zero weights hold every average
        set_weights(16'h0000, 16'h0000, 16'h0000);
        send_bar(32'h0050_0000, 1'b1);
        send_bar(32'h1234_5678, 1'b0);
        send_bar(32'hFFFF_FFFF, 1'b0);

        set_weights(16'h0001, 16'hFFFF, 16'h0001);
        send_bar(32'h0001_0000, 1'b1);
        send_bar(32'hFFFF_0000, 1'b0);
        send_bar(32'h0000_0001, 1'b0);

        set_weights(16'(FAST_WEIGHT_RST), 16'(SLOW_WEIGHT_RST), 16'(SIGNAL_WEIGHT_RST));
        run_random_bars(PHASE_BARS);

        set_weights(16'($urandom), 16'($urandom), 16'($urandom));
        idle_pct = 54;
        run_random_bars(PHASE_BARS);

        set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF);
        idle_pct = 0;
        stall_pct = 54;
        run_random_bars(PHASE_BARS);

        set_weights(16'($urandom), 16'($urandom), 16'($urandom));
        idle_pct = 9;
        stall_pct = 9;
        run_random_bars(PHASE_BARS);

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/macd_pkg.sv
rtl/macd_if.sv
rtl/macd_cfg_regs.sv
rtl/macd_ser_mul.sv
rtl/macd_indicator.sv
tb/sv/macd_indicator_checker.sv
tb/sv/macd_indicator_tb.sv
